/* rtl/bdb_pkg.sv */
// ----------------------------------------------------------------------------
// bdb_pkg: shared types and codes for the bounded deque/bag block
// Holds the transfer structs of the command and result channels, the action
// and status codes, and the default sizing of the store.
// ----------------------------------------------------------------------------
package bdb_pkg;

  // Default sizing of the store.
  localparam int BDB_DEPTH       = 16;
  localparam int BDB_VALUE_WIDTH = 32;

  // Action codes carried in the command.
  localparam logic [2:0] ACT_ADD_FRONT    = 3'd0;
  localparam logic [2:0] ACT_ADD_BACK     = 3'd1;
  localparam logic [2:0] ACT_REMOVE_FRONT = 3'd2;
  localparam logic [2:0] ACT_REMOVE_BACK  = 3'd3;
  localparam logic [2:0] ACT_CONTAINS     = 3'd4;
  localparam logic [2:0] ACT_REMOVE_VALUE = 3'd5;

  // Status codes reported with every result.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         held_count;
    logic               is_empty;
  } out_item_t;

endpackage

/* rtl/bounded_deque_bag_top.sv */
// ----------------------------------------------------------------------------
// bounded_deque_bag_top: bounded double-ended queue with search
// An ordered store of up to DEPTH values that works as a deque and as a bag,
// built on one single-port-read, single-port-write memory and one comparator.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge where start is high and busy is low;
// busy then stays high until the command is finished, so one command is in
// the block at a time. Every command produces exactly one result transfer:
// out_valid is high for a single cycle and the result must be taken in that
// cycle, since the receiver has no way to stall it. The store is a circular
// buffer in one memory with one read port (registered data) and one write
// port, and every read of it goes through a small sequencer; that read port
// sets the timing. End adds and end removals update the store, if they can,
// at the accepting edge, then read the front and the back entry for the
// result (no read when the store ends up empty). A contains command walks
// the held entries from the front, one read per cycle, each compare on the
// data of the read before it, and stops at the first match or after the
// last entry. A remove-value command walks the same way and then, on a
// match, moves every entry behind it one place toward the front, one entry
// per cycle, before the front and back reads. The result is registered and
// comes out in the first cycle that busy is low, so a new command can be
// taken in the same cycle as the strobe. The memory needs no clearing: only
// held entries are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_bag_top
  import bdb_pkg::*;
#(
  parameter int DEPTH       = BDB_DEPTH,
  parameter int VALUE_WIDTH = BDB_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // memory address width
  localparam int CW = $clog2(DEPTH + 1);                // count and position width
  localparam int SW = CW + 1;                           // width of head + position
  localparam int VW = VALUE_WIDTH;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_FRONT = 6'b001000,
    S_BACK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  // Maps a position counted from the front to a memory address. The sum is
  // always below twice DEPTH, so one compare and subtract wraps it.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return AW'(sum);
  endfunction

  state_t          state_r,   state_nxt;
  logic [2:0]      act_r,     act_nxt;
  logic [VW-1:0]   val_r,     val_nxt;
  logic [AW-1:0]   head_r,    head_nxt;
  logic [CW-1:0]   cnt_r,     cnt_nxt;
  logic [CW-1:0]   rd_pos_r,  rd_pos_nxt;
  logic [CW-1:0]   cmp_pos_r, cmp_pos_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]   wr_pos_r,  wr_pos_nxt;
  logic            pend_r,    pend_nxt;
  logic            found_r,   found_nxt;
  logic [1:0]      status_r,  status_nxt;
  logic [VW-1:0]   front_r,   front_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r,  out_data_nxt;

  // Memory ports.
  logic [VW-1:0]   mem [DEPTH];
  logic [VW-1:0]   rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [VW-1:0]   wr_data;

  logic [63:0]     in_ext;
  logic [VW-1:0]   in_val;
  logic            cmp_hit;

  // The command value is kept in its low VALUE_WIDTH bits, zero-extended
  // when the store is wider than the command field.
  assign in_ext  = {32'b0, in_data.value};
  assign in_val  = in_ext[VW-1:0];

  // The single comparator shared by every step of a search.
  assign cmp_hit = cmp_vld_r && (rd_data_r == val_r);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    rd_pos_nxt    = rd_pos_r;
    cmp_pos_nxt   = cmp_pos_r;
    cmp_vld_nxt   = cmp_vld_r;
    wr_pos_nxt    = wr_pos_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    front_nxt     = front_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_val;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt     = in_data.action;
          val_nxt     = in_val;
          found_nxt   = 1'b0;
          status_nxt  = ST_DONE;
          rd_pos_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FRONT;
          case (in_data.action)
            ACT_ADD_FRONT: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                wr_en    = 1'b1;
                wr_addr  = head_nxt;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            ACT_ADD_BACK: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = slot(head_r, cnt_r);
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            ACT_REMOVE_FRONT: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
                cnt_nxt  = cnt_r - CW'(1);
              end
            end
            ACT_REMOVE_BACK: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            ACT_CONTAINS, ACT_REMOVE_VALUE: begin
              if (cnt_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Reads run one entry ahead of the compare.
      S_SCAN: begin
        if (cmp_hit) begin
          found_nxt   = 1'b1;
          cmp_vld_nxt = 1'b0;
          if (act_r == ACT_REMOVE_VALUE) begin
            wr_pos_nxt = cmp_pos_r;
            rd_pos_nxt = cmp_pos_r + CW'(1);
            pend_nxt   = 1'b0;
            state_nxt  = S_SHIFT;
          end else begin
            state_nxt = S_FRONT;
          end
        end else if (cmp_vld_r && (cmp_pos_r == cnt_r - CW'(1))) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_FRONT;
        end else if (rd_pos_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_addr     = slot(head_r, rd_pos_r);
          cmp_pos_nxt = rd_pos_r;
          cmp_vld_nxt = 1'b1;
          rd_pos_nxt  = rd_pos_r + CW'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      // Close the gap: read the entry behind, write it one place forward.
      S_SHIFT: begin
        if (pend_r) begin
          wr_en      = 1'b1;
          wr_addr    = slot(head_r, wr_pos_r);
          wr_data    = rd_data_r;
          wr_pos_nxt = wr_pos_r + CW'(1);
        end
        if (rd_pos_r < cnt_r) begin
          rd_en      = 1'b1;
          rd_addr    = slot(head_r, rd_pos_r);
          rd_pos_nxt = rd_pos_r + CW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_FRONT;
          end
        end
      end

      S_FRONT: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = S_BACK;
        end
      end

      S_BACK: begin
        front_nxt = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = slot(head_r, cnt_r - CW'(1));
        state_nxt = S_FIN;
      end

      S_FIN: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.status      = status_r;
        out_data_nxt.found       = found_r;
        out_data_nxt.held_count  = 5'(cnt_r);
        out_data_nxt.is_empty    = (cnt_r == '0);
        if (cnt_r == '0) begin
          out_data_nxt.front_value = '0;
          out_data_nxt.back_value  = '0;
        end else begin
          out_data_nxt.front_value = 32'(front_r);
          out_data_nxt.back_value  = 32'(rd_data_r);
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    rd_pos_r   <= rd_pos_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    wr_pos_r   <= wr_pos_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    front_r    <= front_nxt;
    out_data_r <= out_data_nxt;
  end

  // Entry store: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded deque/bag block
// Drives commands through the start/busy handshake and keeps a mirror of the
// circular store. Each accepted command is run through the mirror to get the
// result it should produce. A monitor compares every result strobe, field by
// field, with the oldest pending prediction. Directed cases cover the empty
// and full edges and value search. Random traffic then sweeps the fill level
// from empty to full and back.
// ----------------------------------------------------------------------------
module tb_top;
  import bdb_pkg::*;

  localparam int DEPTH       = BDB_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  // Action codes the block treats as no-ops.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  // Mirror of the block's store. Only held entries are ever read from it.
  logic [31:0] mirror_store [DEPTH];
  int          mirror_head = 0;
  int          mirror_count = 0;

  // Results predicted for accepted commands, oldest first.
  out_item_t   pending_results [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  // A few interesting values, so that searches hit often.
  logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                                  32'hAAAA_AAAA, 32'h0000_002A};

  bounded_deque_bag_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Position from the front of the first held copy of v, or the count if none.
  function automatic int mirror_find(logic [31:0] v);
    for (int i = 0; i < mirror_count; i++) begin
      if (mirror_store[(mirror_head + i) % DEPTH] == v) return i;
    end
    return mirror_count;
  endfunction

  // Applies one command to the mirror and returns the result it must give.
  function automatic out_item_t deque_predict(in_item_t cmd);
    out_item_t   r;
    int          pos;
    logic [31:0] v;
    r = '0;
    r.status = ST_DONE;
    v = cmd.value;
    case (cmd.action)
      ACT_ADD_FRONT: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_store[mirror_head] = v;
          mirror_count++;
        end
      end
      ACT_ADD_BACK: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_store[(mirror_head + mirror_count) % DEPTH] = v;
          mirror_count++;
        end
      end
      ACT_REMOVE_FRONT: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      ACT_REMOVE_BACK: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else mirror_count--;
      end
      ACT_CONTAINS: begin
        r.found = (mirror_find(v) < mirror_count);
      end
      ACT_REMOVE_VALUE: begin
        pos = mirror_find(v);
        if (pos < mirror_count) begin
          r.found = 1'b1;
          // Entries behind the match close the gap, keeping their order.
          for (int i = pos; i + 1 < mirror_count; i++) begin
            mirror_store[(mirror_head + i) % DEPTH] =
              mirror_store[(mirror_head + i + 1) % DEPTH];
          end
          mirror_count--;
        end
      end
      default: begin
      end
    endcase
    if (mirror_count != 0) begin
      r.front_value = mirror_store[mirror_head];
      r.back_value  = mirror_store[(mirror_head + mirror_count - 1) % DEPTH];
    end
    r.held_count = mirror_count[4:0];
    r.is_empty   = (mirror_count == 0);
    return r;
  endfunction

  // Idle cycles before the next command: mostly a random pause, with
  // occasional back-to-back bursts so that no-gap traffic is also seen.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Sends one command and waits for its transfer. It is called at a rising
  // edge; start stays high from one command to the next when no gap is drawn,
  // so it is never lowered and raised within the same time step.
  task automatic send_command(logic [2:0] act, logic [31:0] val);
    in_item_t cmd;
    int       gap;
    cmd.action = act;
    cmd.value  = val;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    // busy is sampled as it stood at the edge, before this step's updates.
    do @(posedge clk); while (busy);
    pending_results.push_back(deque_predict(cmd));
  endtask

  // Search and removal values lean toward entries that are actually held.
  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4 && mirror_count > 0)
      return mirror_store[(mirror_head + $urandom_range(0, mirror_count - 1)) % DEPTH];
    if (k < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Random commands with the given share of adds and end removals; the rest
  // are searches and value removals, plus a little no-op noise.
  task automatic run_random(int n, int add_pct, int remove_pct);
    int          r;
    logic [2:0]  act;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct)
        act = $urandom_range(0, 1) ? ACT_ADD_FRONT : ACT_ADD_BACK;
      else if (r < add_pct + remove_pct)
        act = $urandom_range(0, 1) ? ACT_REMOVE_FRONT : ACT_REMOVE_BACK;
      else if (r < 97)
        act = $urandom_range(0, 1) ? ACT_CONTAINS : ACT_REMOVE_VALUE;
      else
        act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
      send_command(act, pick_value());
    end
  endtask

  // Each removal, search and spare command on an empty store: end removals are
  // refused, searches miss, and the spare codes change nothing.
  task automatic test_empty_store();
    send_command(ACT_REMOVE_FRONT, 32'h0000_0000);
    send_command(ACT_REMOVE_BACK, 32'hFFFF_FFFF);
    send_command(ACT_CONTAINS, 32'h0000_0000);
    send_command(ACT_REMOVE_VALUE, 32'h0000_0000);
    send_command(ACT_SPARE_A, 32'h1234_5678);
    send_command(ACT_SPARE_B, 32'h8765_4321);
  endtask

  // Fills the store from both ends with extreme values and a duplicate, then
  // tries to add at each end of the full store.
  task automatic test_fill_and_overflow();
    send_command(ACT_ADD_BACK, 32'h7FFF_FFFF);
    send_command(ACT_ADD_FRONT, 32'h8000_0000);
    send_command(ACT_ADD_BACK, 32'hFFFF_FFFF);
    send_command(ACT_ADD_FRONT, 32'h0000_0000);
    send_command(ACT_ADD_BACK, 32'h5555_5555);
    send_command(ACT_ADD_FRONT, 32'hAAAA_AAAA);
    send_command(ACT_ADD_BACK, 32'h0000_0005);
    send_command(ACT_ADD_FRONT, 32'h0000_0005);
    while (mirror_count < DEPTH) begin
      send_command(mirror_count[0] ? ACT_ADD_FRONT : ACT_ADD_BACK, $urandom);
    end
    send_command(ACT_ADD_FRONT, 32'h0000_0001);
    send_command(ACT_ADD_BACK, 32'h0000_0002);
  endtask

  // On the full store: a hit, a miss, removal of the front copy of a
  // duplicated value, removal from the middle, and removal of an absent value.
  task automatic test_search_and_remove_value();
    send_command(ACT_CONTAINS, 32'h0000_0005);
    send_command(ACT_CONTAINS, 32'h1234_5678);
    send_command(ACT_REMOVE_VALUE, 32'h0000_0005);
    send_command(ACT_REMOVE_VALUE, 32'h7FFF_FFFF);
    send_command(ACT_REMOVE_VALUE, 32'h1234_5678);
  endtask

  task automatic test_random_balanced();
    run_random(300, 35, 30);
  endtask

  // Adds dominate, so the store sits at full and overflows are frequent.
  task automatic test_random_fill();
    run_random(250, 60, 15);
  endtask

  // Removals dominate, so the store drains and empty refusals are frequent.
  task automatic test_random_drain();
    run_random(250, 15, 55);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result monitor. The receiver cannot stall, so every strobe is one
  // transfer, and it is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("found", want.found, out_data.found);
        check_field("front_value", want.front_value, out_data.front_value);
        check_field("back_value", want.back_value, out_data.back_value);
        check_field("held_count", want.held_count, out_data.held_count);
        check_field("is_empty", want.is_empty, out_data.is_empty);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    // Synchronous reset, held low from the start, then released at an edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_fill_and_overflow();
    test_search_and_remove_value();
    test_random_balanced();
    test_random_fill();
    test_random_drain();

    // Drain: wait for every predicted result, then give the block time to
    // show any stray strobe.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bdb_pkg.sv
rtl/bounded_deque_bag_top.sv
tb/tb_top.sv
